// ===== rtl/mpow2_pkg.sv =====
`timescale 1ns / 1ps

package mpow2_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned NENT      = 4;
  localparam int unsigned STEP_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_00 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_01 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_10 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_11 = CFG_IDX_W'(3);

  localparam logic [DATA_W-1:0] CFG_RESET_DIAG = 32'h8000_0000;
  localparam logic [DATA_W-1:0] CFG_RESET_OFF  = 32'h0000_0000;
  localparam logic [DATA_W-1:0] ALL_ONES       = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_DRAIN,
    ST_COMMIT,
    ST_DONE
  } state_e;

  // result times base, or base squared
  typedef enum logic {
    MODE_RB,
    MODE_BB
  } mode_e;

  typedef struct packed {
    logic              load;
    logic              issue;
    logic [STEP_W-1:0] step;
    mode_e             mode;
    logic              commit;
    logic              shift;
    logic              done;
  } cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic rem_lsb;
  } status_t;

endpackage

// ===== rtl/matrix_power_2x2_fixed.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                   payload
// request   in         start_i high, busy_o low    exponent_i
// result    out        done_o one-cycle strobe     power_00_o .. power_11_o
// config    in         cfg_valid_i & cfg_ready_o   cfg_index_i, cfg_data_i
//
// one request walks the exponent bits from the lsb up to the highest set bit;
// a set bit costs a result-times-base product before the base is squared
// every 2x2 product is eight passes through one shared 32x32 multiplier
// plus a drain state and a commit state
// rst_ni clears the controller and restores the configured base matrix to identity at the default FRAC_BITS
// results cannot be stalled; busy_o stays high until the done_o cycle ends
module matrix_power_2x2_fixed #(
  parameter int unsigned EXP_BITS  = 32,
  parameter int unsigned FRAC_BITS = 31
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [mpow2_pkg::DATA_W-1:0]       exponent_i,
  output logic                               done_o,
  output logic [mpow2_pkg::DATA_W-1:0]       power_00_o,
  output logic [mpow2_pkg::DATA_W-1:0]       power_01_o,
  output logic [mpow2_pkg::DATA_W-1:0]       power_10_o,
  output logic [mpow2_pkg::DATA_W-1:0]       power_11_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mpow2_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mpow2_pkg::DATA_W-1:0]       cfg_data_i
);

  mpow2_pkg::cmd_t                 cmd;
  mpow2_pkg::status_t              sts;
  logic [mpow2_pkg::DATA_W-1:0]    res [mpow2_pkg::NENT];

  assign cfg_ready_o = 1'b1;

  mpow2_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  mpow2_dp #(
    .EXP_BITS  (EXP_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .exponent_i  (exponent_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (res)
  );

  assign done_o     = cmd.done;
  assign power_00_o = res[0];
  assign power_01_o = res[1];
  assign power_10_o = res[2];
  assign power_11_o = res[3];

endmodule

// ===== rtl/mpow2_ctrl.sv =====
`timescale 1ns / 1ps

module mpow2_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  mpow2_pkg::status_t  sts_i,
  output mpow2_pkg::cmd_t     cmd_o,
  output logic                busy_o
);

  mpow2_pkg::state_e                 state_q, state_d;
  mpow2_pkg::mode_e                  mode_q, mode_d;
  logic [mpow2_pkg::STEP_W-1:0]      cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpow2_pkg::ST_IDLE;
      mode_q  <= mpow2_pkg::MODE_RB;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    cnt_d        = cnt_q;
    cmd_o        = '0;
    cmd_o.mode   = mode_q;
    cmd_o.step   = cnt_q;
    busy_o       = 1'b1;
    unique case (state_q)
      mpow2_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = mpow2_pkg::ST_CHECK;
        end
      end
      mpow2_pkg::ST_CHECK: begin
        if (sts_i.rem_zero) begin
          state_d = mpow2_pkg::ST_DONE;
        end else begin
          mode_d  = sts_i.rem_lsb ? mpow2_pkg::MODE_RB : mpow2_pkg::MODE_BB;
          cnt_d   = '0;
          state_d = mpow2_pkg::ST_RUN;
        end
      end
      mpow2_pkg::ST_RUN: begin
        cmd_o.issue = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = mpow2_pkg::ST_DRAIN;
        end
      end
      mpow2_pkg::ST_DRAIN: begin
        state_d = mpow2_pkg::ST_COMMIT;
      end
      mpow2_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        if (mode_q == mpow2_pkg::MODE_RB) begin
          mode_d  = mpow2_pkg::MODE_BB;
          cnt_d   = '0;
          state_d = mpow2_pkg::ST_RUN;
        end else begin
          cmd_o.shift = 1'b1;
          state_d     = mpow2_pkg::ST_CHECK;
        end
      end
      mpow2_pkg::ST_DONE: begin
        cmd_o.done = 1'b1;
        state_d    = mpow2_pkg::ST_IDLE;
      end
      default: begin
        state_d = mpow2_pkg::ST_IDLE;
      end
    endcase
  end

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.done |=> state_q == mpow2_pkg::ST_IDLE)
    else $error("done not followed by idle");

  a_start_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> state_q == mpow2_pkg::ST_CHECK)
    else $error("accepted request did not load");

  a_commit_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> $past(state_q) == mpow2_pkg::ST_DRAIN)
    else $error("commit without drained products");

  a_zero_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpow2_pkg::ST_CHECK && sts_i.rem_zero) |=> cmd_o.done)
    else $error("exhausted exponent did not finish");

endmodule

// ===== rtl/mpow2_dp.sv =====
`timescale 1ns / 1ps

module mpow2_dp #(
  parameter int unsigned EXP_BITS  = 32,
  parameter int unsigned FRAC_BITS = 31
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mpow2_pkg::cmd_t                      cmd_i,
  output mpow2_pkg::status_t                   sts_o,
  input  logic [mpow2_pkg::DATA_W-1:0]         exponent_i,
  input  logic                                 cfg_we_i,
  input  logic [mpow2_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mpow2_pkg::DATA_W-1:0]         cfg_data_i,
  output logic [mpow2_pkg::DATA_W-1:0]         res_o [mpow2_pkg::NENT]
);

  localparam int unsigned DW    = mpow2_pkg::DATA_W;
  localparam int unsigned PW    = 2 * DW;
  localparam int unsigned REM_W = (EXP_BITS < DW) ? EXP_BITS : DW;
  localparam logic [PW-1:0] ONE_WIDE = PW'(1) << FRAC_BITS;
  localparam logic [DW-1:0] FX_ONE   =
    (ONE_WIDE[PW-1:DW] != '0) ? mpow2_pkg::ALL_ONES : ONE_WIDE[DW-1:0];

  logic [DW-1:0]    cfg_q  [mpow2_pkg::NENT];
  logic [DW-1:0]    res_q  [mpow2_pkg::NENT];
  logic [DW-1:0]    base_q [mpow2_pkg::NENT];
  logic [DW-1:0]    tmp_q  [mpow2_pkg::NENT];
  logic [REM_W-1:0] rem_q;
  logic [PW-1:0]    prod_q;
  logic [1:0]       pent_q;
  logic             pk_q;
  logic             pvld_q;

  logic [DW-1:0]    op_x, op_y;
  logic [PW-1:0]    prod_sh;
  logic [DW-1:0]    prod_sat;
  logic [DW:0]      acc_sum;
  logic [DW-1:0]    acc_new;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0] <= mpow2_pkg::CFG_RESET_DIAG;
      cfg_q[1] <= mpow2_pkg::CFG_RESET_OFF;
      cfg_q[2] <= mpow2_pkg::CFG_RESET_OFF;
      cfg_q[3] <= mpow2_pkg::CFG_RESET_DIAG;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mpow2_pkg::CFG_ENTRY_00: cfg_q[0] <= cfg_data_i;
        mpow2_pkg::CFG_ENTRY_01: cfg_q[1] <= cfg_data_i;
        mpow2_pkg::CFG_ENTRY_10: cfg_q[2] <= cfg_data_i;
        mpow2_pkg::CFG_ENTRY_11: cfg_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // step = {entry, k}; x[i][k] * y[k][j]
  always_comb begin
    case (cmd_i.step)
      3'd0: begin
        op_x = (cmd_i.mode == mpow2_pkg::MODE_RB) ? res_q[0] : base_q[0];
        op_y = base_q[0];
      end
      3'd1: begin
        op_x = (cmd_i.mode == mpow2_pkg::MODE_RB) ? res_q[1] : base_q[1];
        op_y = base_q[2];
      end
      3'd2: begin
        op_x = (cmd_i.mode == mpow2_pkg::MODE_RB) ? res_q[0] : base_q[0];
        op_y = base_q[1];
      end
      3'd3: begin
        op_x = (cmd_i.mode == mpow2_pkg::MODE_RB) ? res_q[1] : base_q[1];
        op_y = base_q[3];
      end
      3'd4: begin
        op_x = (cmd_i.mode == mpow2_pkg::MODE_RB) ? res_q[2] : base_q[2];
        op_y = base_q[0];
      end
      3'd5: begin
        op_x = (cmd_i.mode == mpow2_pkg::MODE_RB) ? res_q[3] : base_q[3];
        op_y = base_q[2];
      end
      3'd6: begin
        op_x = (cmd_i.mode == mpow2_pkg::MODE_RB) ? res_q[2] : base_q[2];
        op_y = base_q[1];
      end
      default: begin
        op_x = (cmd_i.mode == mpow2_pkg::MODE_RB) ? res_q[3] : base_q[3];
        op_y = base_q[3];
      end
    endcase
  end

  // shared multiplier, product registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      prod_q <= PW'(op_x) * PW'(op_y);
      pent_q <= cmd_i.step[2:1];
      pk_q   <= cmd_i.step[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else begin
      pvld_q <= cmd_i.issue;
    end
  end

  // truncate, saturate, accumulate
  always_comb begin
    prod_sh  = prod_q >> FRAC_BITS;
    prod_sat = (prod_sh[PW-1:DW] != '0) ? mpow2_pkg::ALL_ONES : prod_sh[DW-1:0];
    acc_sum  = {1'b0, tmp_q[pent_q]} + {1'b0, prod_sat};
    if (!pk_q) begin
      acc_new = prod_sat;
    end else if (acc_sum[DW]) begin
      acc_new = mpow2_pkg::ALL_ONES;
    end else begin
      acc_new = acc_sum[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pvld_q) begin
      tmp_q[pent_q] <= acc_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q[0]  <= FX_ONE;
      res_q[1]  <= '0;
      res_q[2]  <= '0;
      res_q[3]  <= FX_ONE;
      base_q    <= cfg_q;
    end else if (cmd_i.commit) begin
      if (cmd_i.mode == mpow2_pkg::MODE_RB) begin
        res_q <= tmp_q;
      end else begin
        base_q <= tmp_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (cmd_i.load) begin
      rem_q <= exponent_i[REM_W-1:0];
    end else if (cmd_i.shift) begin
      rem_q <= rem_q >> 1;
    end
  end

  assign sts_o.rem_zero = (rem_q == '0);
  assign sts_o.rem_lsb  = rem_q[0];
  assign res_o          = res_q;

  a_load_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (res_q[1] == '0 && res_q[2] == '0 && res_q[0] == FX_ONE))
    else $error("result not reset to identity");

  a_shift_halves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.shift && !cmd_i.load) |=> rem_q == ($past(rem_q) >> 1))
    else $error("exponent not shifted");

  a_no_accum_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !pvld_q && !cmd_i.issue)
    else $error("commit while products in flight");

endmodule
